>>> hw/rtl/ssw_pkg.sv
// Package for the seven-segment serial writer: symbol types, commands and the digit table.
`default_nettype none
package ssw_pkg;

  localparam int unsigned NumCells = 58;

  localparam logic [7:0] DataCommand    = 8'd64;
  localparam logic [7:0] AddressCommand = 8'd192;
  localparam logic [7:0] ControlCommand = 8'd128;

  localparam int unsigned NumDigits = 4;

  typedef enum logic [1:0] {
    SymStart = 2'd0,
    SymBit   = 2'd1,
    SymAck   = 2'd2,
    SymStop  = 2'd3
  } sym_kind_e;

  typedef struct packed {
    logic      valid;
    sym_kind_e symbol;
    logic      bit_value;
    logic      last;
  } sym_t;

  typedef struct packed {
    logic load;
    logic shift;
  } cell_ctrl_t;

  function automatic logic [7:0] seg_lookup(input logic [3:0] code);
    logic [7:0] seg;
    case (code)
      4'd0:    seg = 8'h3F;
      4'd1:    seg = 8'h06;
      4'd2:    seg = 8'h5B;
      4'd3:    seg = 8'h4F;
      4'd4:    seg = 8'h66;
      4'd5:    seg = 8'h6D;
      4'd6:    seg = 8'h7D;
      4'd7:    seg = 8'h07;
      4'd8:    seg = 8'h7F;
      4'd9:    seg = 8'h6F;
      4'd11:   seg = 8'h08;
      default: seg = 8'h00;
    endcase
    return seg;
  endfunction

  function automatic sym_t mk_sym(input sym_kind_e kind, input logic val, input logic lst);
    sym_t s;
    s.valid     = 1'b1;
    s.symbol    = kind;
    s.bit_value = val;
    s.last      = lst;
    return s;
  endfunction

endpackage
`default_nettype wire

>>> hw/rtl/ssw_frame_build.sv
// Builds the full symbol frame for one request, one entry per chain cell.
`default_nettype none
module ssw_frame_build (
  input  logic                          mode_i,
  input  logic [3:0]                    brightness_i,
  input  logic [ssw_pkg::NumDigits-1:0][3:0] digits_i,
  output ssw_pkg::sym_t [ssw_pkg::NumCells-1:0] frame_o
);
  import ssw_pkg::*;

  logic [7:0] ctrl_byte;
  logic [NumDigits-1:0][7:0] seg_bytes;

  assign ctrl_byte = ControlCommand | {4'd0, brightness_i};

  always_comb begin
    for (int k = 0; k < NumDigits; k++) begin
      seg_bytes[k] = seg_lookup(digits_i[k]);
    end
  end

  always_comb begin
    for (int c = 0; c < NumCells; c++) begin
      frame_o[c] = '0;
    end
    frame_o[0] = mk_sym(SymStart, 1'b1, 1'b0);
    if (!mode_i) begin
      for (int i = 0; i < 8; i++) begin
        frame_o[1 + i] = mk_sym(SymBit, ctrl_byte[i], 1'b0);
      end
      frame_o[9]  = mk_sym(SymAck, 1'b1, 1'b0);
      frame_o[10] = mk_sym(SymStop, 1'b1, 1'b1);
    end else begin
      for (int i = 0; i < 8; i++) begin
        frame_o[1 + i]  = mk_sym(SymBit, DataCommand[i], 1'b0);
        frame_o[12 + i] = mk_sym(SymBit, AddressCommand[i], 1'b0);
      end
      frame_o[9]  = mk_sym(SymAck, 1'b1, 1'b0);
      frame_o[10] = mk_sym(SymStop, 1'b1, 1'b0);
      frame_o[11] = mk_sym(SymStart, 1'b1, 1'b0);
      frame_o[20] = mk_sym(SymAck, 1'b1, 1'b0);
      for (int k = 0; k < NumDigits; k++) begin
        for (int i = 0; i < 8; i++) begin
          frame_o[21 + 9 * k + i] = mk_sym(SymBit, seg_bytes[k][i], 1'b0);
        end
        frame_o[29 + 9 * k] = mk_sym(SymAck, 1'b1, 1'b0);
      end
      frame_o[NumCells-1] = mk_sym(SymStop, 1'b1, 1'b1);
    end
  end

endmodule
`default_nettype wire

>>> hw/rtl/ssw_cell.sv
// One symbol cell of the output shift chain.
`default_nettype none
module ssw_cell (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  ssw_pkg::cell_ctrl_t ctrl_i,
  input  ssw_pkg::sym_t       load_i,
  input  ssw_pkg::sym_t       next_i,
  output ssw_pkg::sym_t       cell_o
);
  import ssw_pkg::*;

  sym_t cell_d, cell_q;

  always_comb begin
    cell_d = cell_q;
    if (ctrl_i.load) begin
      cell_d = load_i;
    end else if (ctrl_i.shift) begin
      cell_d = next_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cell_q <= '0;
    end else begin
      cell_q <= cell_d;
    end
  end

  assign cell_o = cell_q;

endmodule
`default_nettype wire

>>> hw/rtl/seven_segment_serial_writer_unit.sv
// Top level of the seven-segment serial writer: frame builder, cell chain, output register.
//
// Channel   Dir  tdata                                   tuser      tlast
// s_axis    in   brightness, digit_0..digit_3 (24 b)     mode       -
// m_axis    out  bit_value (8 b)                         symbol     last
//
// A request loads its whole frame at once into a 58-cell shift chain; while m_axis
// is not stalled, one symbol a cycle then moves to the output register: a control
// write is 11 symbols, a digit write 58. A new request is taken once the chain
// head is empty or its final symbol moves out, so frames follow with no gap.
// Reset clears the chain and the output register. A stall on m_axis freezes the chain.
`default_nettype none
module seven_segment_serial_writer_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [23:0] s_axis_tdata,  // [3:0] brightness, [7:4] digit_0, [11:8] digit_1,
                                     // [15:12] digit_2, [19:16] digit_3, [23:20] zero
  input  logic        s_axis_tuser,  // [0] mode
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [7:0]  m_axis_tdata,  // [0] bit_value, [7:1] zero
  output logic [1:0]  m_axis_tuser,  // [1:0] symbol
  output logic        m_axis_tlast   // last
);
  import ssw_pkg::*;

  sym_t [NumCells-1:0] frame;
  sym_t [NumCells-1:0] cells;
  sym_t [NumCells-1:0] nexts;
  sym_t                out_d, out_q;
  cell_ctrl_t          ctrl;
  logic [NumDigits-1:0][3:0] digits;
  logic                in_acc;
  logic                advance;

  assign digits        = s_axis_tdata[19:4];
  assign s_axis_tready = !cells[0].valid || (!cells[1].valid && advance);
  assign in_acc        = s_axis_tvalid && s_axis_tready;
  assign advance       = !out_q.valid || m_axis_tready;
  assign ctrl.load     = in_acc;
  assign ctrl.shift    = advance;

  ssw_frame_build u_frame (
    .mode_i       (s_axis_tuser),
    .brightness_i (s_axis_tdata[3:0]),
    .digits_i     (digits),
    .frame_o      (frame)
  );

  for (genvar c = 0; c < NumCells; c++) begin : g_chain
    if (c == NumCells - 1) begin : g_tail
      assign nexts[c] = '0;
    end else begin : g_body
      assign nexts[c] = cells[c+1];
    end
    ssw_cell u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .ctrl_i (ctrl),
      .load_i (frame[c]),
      .next_i (nexts[c]),
      .cell_o (cells[c])
    );
  end

  always_comb begin
    out_d = out_q;
    if (advance) begin
      out_d = cells[0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_q <= '0;
    end else begin
      out_q <= out_d;
    end
  end

  assign m_axis_tvalid = out_q.valid;
  assign m_axis_tdata  = {7'd0, out_q.bit_value};
  assign m_axis_tuser  = out_q.symbol;
  assign m_axis_tlast  = out_q.last;

  a_last_is_stop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tlast) |-> (m_axis_tuser == SymStop))
    else $error("last symbol is not a stop");

  a_load_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> (cells[0].valid && cells[0].symbol == SymStart))
    else $error("loaded frame does not open with start");

  a_chain_packed: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !cells[0].valid |-> !cells[1].valid)
    else $error("chain has a gap at its head");

  a_no_data_value: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tuser != SymBit) |-> m_axis_tdata[0])
    else $error("non-data symbol with low line level");

endmodule
`default_nettype wire
